### design/gkcs_pkg.sv
// Shared constants, types and constant functions for the gamma-kernel current source.
`timescale 1ns / 1ps

package gkcs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LOG_STAGES = FRAC_BITS;
    localparam int EXP_STAGES = FRAC_BITS;
    localparam int DIV_STAGES = 12;
    localparam int REG_IDX_W = 3;
    localparam int DATA_W = 32;
    localparam int MANT_W = 31;
    localparam int E_W = 34;
    localparam int N_W = E_W - FRAC_BITS;

    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [30:0] TERM_CAP = 31'h4000_0000;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_AMPLITUDE  = 3'd0,
        REG_DECAY      = 3'd1,
        REG_RISE       = 3'd2,
        REG_SPREAD     = 3'd3,
        REG_DISTANCE   = 3'd4,
        REG_ONSET      = 3'd5,
        REG_START      = 3'd6,
        REG_STOP       = 3'd7
    } reg_idx_t;

    // sideband carried through the log2 pipeline
    typedef struct packed {
        logic        act;
        logic        tz;
        logic [31:0] c_term;
    } log_side_t;

    // sideband carried through the exp2 pipeline
    typedef struct packed {
        logic                  act;
        logic                  tz;
        logic signed [N_W-1:0] n;
    } exp_side_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res = '0;
        bit_v = 64'h4000_0000_0000_0000;
        rem = v;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bit_v)
            begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else
            begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(2^-idx) in Q1.30, built by repeated truncated square roots
    function automatic logic [MANT_W-1:0] exp_root(input int idx);
        logic [63:0] root;
        root = 64'h8000_0000;
        for (int i = 1; i <= idx; i++)
        begin
            root = isqrt64(root << 30);
        end
        return root[MANT_W-1:0];
    endfunction

endpackage

### design/gkcs_gauss.sv
// Free-running Gaussian log-weight unit: restoring divider, square and log2(e) scale.
`timescale 1ns / 1ps

module gkcs_gauss (
    input  logic                      clk,
    input  logic [gkcs_pkg::DATA_W-1:0] distance,
    input  logic [gkcs_pkg::DATA_W-1:0] spread,
    output logic [31:0]               a_term
);
    import gkcs_pkg::*;

    logic [31:0] rem_w [0:DIV_STAGES];
    logic [23:0] quo_w [0:DIV_STAGES];
    logic [23:0] low_bits;
    logic        ovf;
    logic [23:0] ratio;
    logic [47:0] ratio_sq;
    logic [30:0] g_next;
    logic [30:0] g_reg;
    logic [55:0] a_prod;
    logic [31:0] a_reg;

    assign low_bits = {distance[7:0], 16'b0};
    assign rem_w[0] = {8'b0, distance[31:8]};
    assign quo_w[0] = '0;

    // two quotient bits per stage
    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        logic [31:0] rem_next;
        logic [23:0] quo_next;
        logic [31:0] rem_reg;
        logic [23:0] quo_reg;

        always_comb
        begin
            logic [32:0] trial;
            rem_next = rem_w[i];
            quo_next = quo_w[i];
            for (int k = 0; k < 2; k++)
            begin
                trial = {rem_next, low_bits[23 - (2 * i + k)]};
                if (trial >= {1'b0, spread})
                begin
                    trial = trial - {1'b0, spread};
                    quo_next = {quo_next[22:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[22:0], 1'b0};
                end
                rem_next = trial[31:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end

        assign rem_w[i + 1] = rem_reg;
        assign quo_w[i + 1] = quo_reg;
    end

    assign ovf = ({8'b0, distance[31:8]} >= spread);
    assign ratio = ovf ? 24'hFF_FFFF : quo_w[DIV_STAGES];
    assign ratio_sq = ratio * ratio;
    assign g_next = (ratio_sq[47:17] > TERM_CAP) ? TERM_CAP : ratio_sq[47:17];
    assign a_prod = g_reg * LOG2E_Q24;

    always_ff @(posedge clk)
    begin
        g_reg <= g_next;
        a_reg <= a_prod[55:24];
    end

    assign a_term = a_reg;

endmodule

### design/gkcs_log2.sv
// Pipelined log2 fraction: one mantissa squaring per stage.
`timescale 1ns / 1ps

module gkcs_log2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [gkcs_pkg::MANT_W-1:0]       in_mant,
    input  logic [4:0]                        in_msb,
    input  gkcs_pkg::log_side_t               in_side,
    output logic                              out_valid,
    output logic [gkcs_pkg::FRAC_BITS-1:0]    out_frac,
    output logic [4:0]                        out_msb,
    output gkcs_pkg::log_side_t               out_side
);
    import gkcs_pkg::*;

    logic                 valid_w [0:LOG_STAGES];
    logic [MANT_W-1:0]    mant_w  [0:LOG_STAGES];
    logic [FRAC_BITS-1:0] frac_w  [0:LOG_STAGES];
    logic [4:0]           msb_w   [0:LOG_STAGES];
    log_side_t            side_w  [0:LOG_STAGES];

    assign valid_w[0] = in_valid;
    assign mant_w[0] = in_mant;
    assign frac_w[0] = '0;
    assign msb_w[0] = in_msb;
    assign side_w[0] = in_side;

    for (genvar i = 0; i < LOG_STAGES; i++)
    begin : g_stage
        logic [61:0]          sq;
        logic [31:0]          sq_hi;
        logic [MANT_W-1:0]    mant_next;
        logic [FRAC_BITS-1:0] frac_next;
        logic                 valid_reg;
        logic [MANT_W-1:0]    mant_reg;
        logic [FRAC_BITS-1:0] frac_reg;
        logic [4:0]           msb_reg;
        log_side_t            side_reg;

        assign sq = mant_w[i] * mant_w[i];
        assign sq_hi = sq[61:30];
        // mantissa reached [2,4): emit a one and renormalize
        assign mant_next = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
        assign frac_next = {frac_w[i][FRAC_BITS-2:0], sq_hi[31]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_w[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mant_reg <= mant_next;
                frac_reg <= frac_next;
                msb_reg <= msb_w[i];
                side_reg <= side_w[i];
            end
        end

        assign valid_w[i + 1] = valid_reg;
        assign mant_w[i + 1] = mant_reg;
        assign frac_w[i + 1] = frac_reg;
        assign msb_w[i + 1] = msb_reg;
        assign side_w[i + 1] = side_reg;
    end

    assign out_valid = valid_w[LOG_STAGES];
    assign out_frac = frac_w[LOG_STAGES];
    assign out_msb = msb_w[LOG_STAGES];
    assign out_side = side_w[LOG_STAGES];

endmodule

### design/gkcs_exp2.sv
// Pipelined 2^frac in Q1.30: one conditional root multiply per stage.
`timescale 1ns / 1ps

module gkcs_exp2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [gkcs_pkg::FRAC_BITS-1:0]    in_frac,
    input  gkcs_pkg::exp_side_t               in_side,
    output logic                              out_valid,
    output logic [gkcs_pkg::MANT_W-1:0]       out_mant,
    output gkcs_pkg::exp_side_t               out_side
);
    import gkcs_pkg::*;

    logic                 valid_w [0:EXP_STAGES];
    logic [MANT_W-1:0]    acc_w   [0:EXP_STAGES];
    logic [FRAC_BITS-1:0] frac_w  [0:EXP_STAGES];
    exp_side_t            side_w  [0:EXP_STAGES];

    assign valid_w[0] = in_valid;
    assign acc_w[0] = Q30_ONE;
    assign frac_w[0] = in_frac;
    assign side_w[0] = in_side;

    for (genvar i = 0; i < EXP_STAGES; i++)
    begin : g_stage
        localparam logic [MANT_W-1:0] ROOT = exp_root(i + 1);
        logic [61:0]          prod;
        logic [MANT_W-1:0]    acc_next;
        logic                 valid_reg;
        logic [MANT_W-1:0]    acc_reg;
        logic [FRAC_BITS-1:0] frac_reg;
        exp_side_t            side_reg;

        assign prod = acc_w[i] * ROOT;
        assign acc_next = frac_w[i][FRAC_BITS - 1 - i] ? prod[60:30] : acc_w[i];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= valid_w[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg <= acc_next;
                frac_reg <= frac_w[i];
                side_reg <= side_w[i];
            end
        end

        assign valid_w[i + 1] = valid_reg;
        assign acc_w[i + 1] = acc_reg;
        assign frac_w[i + 1] = frac_reg;
        assign side_w[i + 1] = side_reg;
    end

    assign out_valid = valid_w[EXP_STAGES];
    assign out_mant = acc_w[EXP_STAGES];
    assign out_side = side_w[EXP_STAGES];

endmodule

### design/gamma_kernel_current_source_core.sv
// Top level of the gamma-kernel current source: registers, front end, log/exp datapath, output.
`timescale 1ns / 1ps

// One tick is accepted every clock unless the output stalls; its result
// passes 4 front-end stages, 16 log2 squaring stages, 2 exponent stages,
// 16 exp2 root-multiply stages and 3 scale/saturate/output stages, the two
// 16-stage mantissa pipelines making up most of that depth. Back-pressure on
// the output freezes the whole pipeline, so input stall follows output stall
// while a result is held. The Gaussian weight is recomputed continuously
// from the distance and spread registers by a divider pipeline that settles
// long before a tick accepted after a register write needs it.
module gamma_kernel_current_source_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gkcs_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [gkcs_pkg::DATA_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [31:0]                        step_index,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 current_out,
    output logic                               active
);
    import gkcs_pkg::*;

    logic [31:0] amplitude_reg;
    logic [31:0] decay_reg;
    logic [31:0] rise_reg;
    logic [31:0] spread_reg;
    logic [31:0] distance_reg;
    logic [31:0] onset_reg;
    logic [31:0] start_reg;
    logic [31:0] stop_reg;

    logic        en;
    logic [31:0] a_term;

    // front end
    logic        valid1_reg;
    logic [31:0] t1_reg;
    logic        act1_reg;
    logic [31:0] t_next;

    logic        valid2_reg;
    logic [4:0]  msb2_reg;
    logic [MANT_W-1:0] mant2_reg;
    logic [63:0] prod2_reg;
    logic        tz2_reg;
    logic        act2_reg;
    logic [4:0]  msb_next;
    logic [31:0] shl;
    logic [MANT_W-1:0] mant_next;

    logic        valid3_reg;
    logic [4:0]  msb3_reg;
    logic [MANT_W-1:0] mant3_reg;
    logic [30:0] c3_reg;
    logic        tz3_reg;
    logic        act3_reg;
    logic [30:0] c_next;

    logic        valid4_reg;
    logic [4:0]  msb4_reg;
    logic [MANT_W-1:0] mant4_reg;
    logic [31:0] cterm4_reg;
    logic        tz4_reg;
    logic        act4_reg;
    logic [55:0] cterm_prod;
    log_side_t   log_in_side;

    logic        log_valid;
    logic [FRAC_BITS-1:0] log_frac;
    logic [4:0]  log_msb;
    log_side_t   log_side;

    // exponent assembly
    logic        validb_reg;
    logic [28:0] bterm_reg;
    log_side_t   sideb_reg;
    logic [52:0] b_prod;

    logic        valide_reg;
    logic signed [E_W-1:0] e_reg;
    logic        acte_reg;
    logic        tze_reg;
    logic signed [E_W-1:0] e_next;
    exp_side_t   exp_in_side;

    logic        exp_valid;
    logic [MANT_W-1:0] exp_mant;
    exp_side_t   exp_side;

    // scale and saturate
    logic        neg;
    logic [31:0] mag;
    logic [31:0] lim;

    logic        validp_reg;
    logic [62:0] p_reg;
    logic signed [N_W:0] s_reg;
    logic        actp_reg;
    logic        tzp_reg;

    logic        valids_reg;
    logic [94:0] wide_reg;
    logic        big_reg;
    logic        acts_reg;
    logic        tzs_reg;
    logic [94:0] wide_next;
    logic        big_next;
    logic [N_W:0] sh_neg;

    logic        out_valid_reg;
    logic [31:0] current_reg;
    logic        active_reg;
    logic [31:0] sat_mag;
    logic        zero_out;
    logic [31:0] current_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= '0;
            decay_reg <= '0;
            rise_reg <= '0;
            spread_reg <= '0;
            distance_reg <= '0;
            onset_reg <= '0;
            start_reg <= '0;
            stop_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_AMPLITUDE: amplitude_reg <= cfg_data;
                REG_DECAY:     decay_reg <= cfg_data;
                REG_RISE:      rise_reg <= cfg_data;
                REG_SPREAD:    spread_reg <= cfg_data;
                REG_DISTANCE:  distance_reg <= cfg_data;
                REG_ONSET:     onset_reg <= cfg_data;
                REG_START:     start_reg <= cfg_data;
                REG_STOP:      stop_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign en = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    gkcs_gauss u_gauss (
        .clk      (clk),
        .distance (distance_reg),
        .spread   (spread_reg),
        .a_term   (a_term)
    );

    // stage 1: elapsed time and window
    assign t_next = (step_index > onset_reg) ? step_index - onset_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            valid4_reg <= 1'b0;
            validb_reg <= 1'b0;
            valide_reg <= 1'b0;
            validp_reg <= 1'b0;
            valids_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            valid4_reg <= valid3_reg;
            validb_reg <= log_valid;
            valide_reg <= validb_reg;
            validp_reg <= exp_valid;
            valids_reg <= validp_reg;
            out_valid_reg <= valids_reg;
        end
    end

    // stage 2: normalize t, decay product
    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (t1_reg[i])
            begin
                msb_next = 5'(i);
            end
        end
    end

    assign shl = t1_reg << (5'd30 - msb_next);
    assign mant_next = (msb_next == 5'd31) ? t1_reg[31:1] : shl[MANT_W-1:0];

    // stage 3: cap decay exponent
    assign c_next = (prod2_reg[63:8] > 56'(TERM_CAP)) ? TERM_CAP : prod2_reg[38:8];

    // stage 4: scale by log2(e)
    assign cterm_prod = c3_reg * LOG2E_Q24;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= t_next;
            act1_reg <= (step_index > start_reg) && (step_index <= stop_reg);

            msb2_reg <= msb_next;
            mant2_reg <= mant_next;
            prod2_reg <= decay_reg * t1_reg;
            tz2_reg <= (t1_reg == '0);
            act2_reg <= act1_reg;

            msb3_reg <= msb2_reg;
            mant3_reg <= mant2_reg;
            c3_reg <= c_next;
            tz3_reg <= tz2_reg;
            act3_reg <= act2_reg;

            msb4_reg <= msb3_reg;
            mant4_reg <= mant3_reg;
            cterm4_reg <= cterm_prod[55:24];
            tz4_reg <= tz3_reg;
            act4_reg <= act3_reg;
        end
    end

    assign log_in_side.act = act4_reg;
    assign log_in_side.tz = tz4_reg;
    assign log_in_side.c_term = cterm4_reg;

    gkcs_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid4_reg),
        .in_mant   (mant4_reg),
        .in_msb    (msb4_reg),
        .in_side   (log_in_side),
        .out_valid (log_valid),
        .out_frac  (log_frac),
        .out_msb   (log_msb),
        .out_side  (log_side)
    );

    // power term, then E = B - A - C split into integer and fraction
    assign b_prod = rise_reg * {log_msb, log_frac};
    assign e_next = $signed({5'b0, bterm_reg}) - $signed({2'b0, a_term})
                    - $signed({2'b0, sideb_reg.c_term});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bterm_reg <= log_side.tz ? '0 : b_prod[52:24];
            sideb_reg <= log_side;
            e_reg <= e_next;
            acte_reg <= sideb_reg.act;
            tze_reg <= sideb_reg.tz;
        end
    end

    assign exp_in_side.act = acte_reg;
    assign exp_in_side.tz = tze_reg;
    assign exp_in_side.n = e_reg[E_W-1:FRAC_BITS];

    gkcs_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valide_reg),
        .in_frac   (e_reg[FRAC_BITS-1:0]),
        .in_side   (exp_in_side),
        .out_valid (exp_valid),
        .out_mant  (exp_mant),
        .out_side  (exp_side)
    );

    assign neg = amplitude_reg[31];
    assign mag = neg ? (~amplitude_reg + 32'd1) : amplitude_reg;
    assign lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;

    // shift by n - 30, flag certain overflow
    assign sh_neg = (N_W + 1)'(-s_reg);

    always_comb
    begin
        big_next = 1'b0;
        wide_next = '0;
        if (!s_reg[N_W])
        begin
            if (s_reg >= (N_W + 1)'(33))
            begin
                big_next = 1'b1;
            end
            else
            begin
                wide_next = {32'b0, p_reg} << s_reg[5:0];
            end
        end
        else if (sh_neg < (N_W + 1)'(63))
        begin
            wide_next = {32'b0, p_reg} >> sh_neg[5:0];
        end
    end

    assign sat_mag = (big_reg || (wide_reg > 95'(lim))) ? lim : wide_reg[31:0];
    assign zero_out = !acts_reg || (spread_reg == '0) || (amplitude_reg == '0)
                      || (tzs_reg && (rise_reg != '0));
    assign current_next = zero_out ? '0 : (neg ? (~sat_mag + 32'd1) : sat_mag);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= mag * exp_mant;
            s_reg <= (N_W + 1)'(exp_side.n) - (N_W + 1)'(30);
            actp_reg <= exp_side.act;
            tzp_reg <= exp_side.tz;

            wide_reg <= wide_next;
            big_reg <= big_next;
            acts_reg <= actp_reg;
            tzs_reg <= tzp_reg;

            current_reg <= current_next;
            active_reg <= acts_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign current_out = current_reg;
    assign active = active_reg;

endmodule
